/* sv/i2cps_pkg.sv */
// i2cps_pkg: command and step payload types, command codes and constants
// for the I2C master pin sequencer. No dependencies.
`timescale 1ns / 1ps

package i2cps_pkg;

    // command codes
    localparam logic [2:0] KIND_START  = 3'd0;
    localparam logic [2:0] KIND_STOP   = 3'd1;
    localparam logic [2:0] KIND_BRESET = 3'd2;
    localparam logic [2:0] KIND_WRITE  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;
    localparam logic [2:0] KIND_ADDR7  = 3'd5;
    localparam logic [2:0] KIND_ADDR10 = 3'd6;

    // pin codes
    localparam logic PIN_SCL = 1'b0;
    localparam logic PIN_SDA = 1'b1;

    // 10-bit address first byte prefix
    localparam logic [7:0] ADDR10_PREFIX = 8'hF0;

    // step counter layout within one byte transfer
    localparam int         BITS_PER_BYTE = 8;
    localparam logic [4:0] BYTE_BITS_END = 5'(3 * BITS_PER_BYTE); // first ack-slot step
    localparam logic [4:0] BYTE_LAST     = 5'(3 * BITS_PER_BYTE + 3);
    localparam logic [4:0] SHORT_LAST    = 5'd3;   // start, stop
    localparam logic [4:0] LONG_LAST     = 5'd19;  // bus reset, read
    localparam logic [4:0] PULSE_END     = 5'(2 * BITS_PER_BYTE); // reset pulses done
    localparam logic [4:0] READ_ACK_STEP = 5'(2 * BITS_PER_BYTE + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [1:0] addr_high_bits;
        logic       read_flag;
        logic       nack_after_read;
        logic [7:0] sda_read_bits;
        logic [1:0] sda_ack_bits;
    } cmd_t;

    typedef struct packed {
        logic       pin_select;
        logic       pin_level;
        logic [7:0] read_byte;
        logic       ack_status;
        logic       last_step;
    } step_t;

    // sequencer state handed to the step decoder
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] cnt;
        logic       byte_idx;
        logic       nack;
        logic [7:0] sread;
        logic [1:0] sack;
    } seq_t;

endpackage

/* sv/i2c_master_pin_sequencer_core.sv */
// i2c_master_pin_sequencer_core: top level of the I2C master pin sequencer.
// Depends on i2cps_pkg and i2cps_step.
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// cmd      in   cmd_valid/cmd_ready  i2cps_pkg::cmd_t, one bus command
// step     out  step_valid/step_ready i2cps_pkg::step_t, one pin change
//
// One command yields one pin change per cycle while the step side takes them:
// 4 steps for start/stop, 20 for bus reset/read, 28 for write and addr7,
// 28 or 56 for addr10 (the step counter and byte shifter set this); the steps
// follow the cycle in which the command transfer is taken.
// cmd_ready is high only while no command is in progress; reset leaves the
// block idle with no step pending. A stall on step_ready freezes the
// sequencer with the pending step held in the output register.

module i2c_master_pin_sequencer_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  i2cps_pkg::cmd_t   cmd,
    output logic              step_valid,
    input  logic              step_ready,
    output i2cps_pkg::step_t  step
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         kind_reg;
    logic [4:0]         cnt_reg, cnt_next;
    logic [1:0]         ph_reg, ph_next;      // phase within one data bit
    logic [7:0]         shift_reg, shift_next;
    logic               byte_idx_reg, byte_idx_next;
    logic [7:0]         low_byte_reg;         // second byte of a 10-bit address
    logic               nack_reg;
    logic [7:0]         sread_reg;
    logic [1:0]         sack_reg;
    logic               out_valid_reg;
    i2cps_pkg::step_t   out_reg;

    i2cps_pkg::seq_t    seq;
    i2cps_pkg::step_t   dec_step;
    i2cps_pkg::step_t   cur_step;
    logic               byte_done;
    logic               advance;
    logic               cmd_fire;
    logic               in_bits;
    logic [7:0]         first_byte;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd_valid && cmd_ready;
    assign step_valid = out_valid_reg;
    assign step       = out_reg;
    // a new step is produced whenever the output slot is free or being emptied
    assign advance    = (state_reg == ST_RUN) && (!out_valid_reg || step_ready);

    assign seq.kind      = kind_reg;
    assign seq.cnt       = cnt_reg;
    assign seq.byte_idx  = byte_idx_reg;
    assign seq.nack      = nack_reg;
    assign seq.sread     = sread_reg;
    assign seq.sack      = sack_reg;

    i2cps_step u_step
    (
        .st        (seq),
        .step      (dec_step),
        .byte_done (byte_done)
    );

    // data-bit part of a byte transfer: SCL low, SDA = bit, SCL high
    assign in_bits = (kind_reg == i2cps_pkg::KIND_WRITE || kind_reg == i2cps_pkg::KIND_ADDR7 ||
                      kind_reg == i2cps_pkg::KIND_ADDR10) &&
                     (cnt_reg < i2cps_pkg::BYTE_BITS_END);

    always_comb
    begin
        cur_step = dec_step;
        if (in_bits)
        begin
            case (ph_reg)
                2'd1:
                begin
                    cur_step.pin_select = i2cps_pkg::PIN_SDA;
                    cur_step.pin_level  = shift_reg[7];
                end
                2'd2:
                begin
                    cur_step.pin_select = i2cps_pkg::PIN_SCL;
                    cur_step.pin_level  = 1'b1;
                end
                default:
                begin
                    cur_step.pin_select = i2cps_pkg::PIN_SCL;
                    cur_step.pin_level  = 1'b0;
                end
            endcase
        end
    end

    // byte loaded into the shifter when a command is taken
    always_comb
    begin
        case (cmd.kind)
            i2cps_pkg::KIND_ADDR7:
                first_byte = {cmd.data_byte[6:0], cmd.read_flag};
            i2cps_pkg::KIND_ADDR10:
                first_byte = i2cps_pkg::ADDR10_PREFIX |
                             {5'b00000, cmd.addr_high_bits, cmd.read_flag};
            default:
                first_byte = cmd.data_byte;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ph_next       = ph_reg;
        shift_next    = shift_reg;
        byte_idx_next = byte_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    cnt_next      = '0;
                    ph_next       = '0;
                    shift_next    = first_byte;
                    byte_idx_next = 1'b0;
                    // the undefined code produces no steps
                    if (cmd.kind <= i2cps_pkg::KIND_ADDR10)
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (cur_step.last_step)
                        state_next = ST_IDLE;
                    else if (byte_done)
                    begin
                        // first 10-bit address byte acknowledged: send low byte
                        cnt_next      = '0;
                        ph_next       = '0;
                        shift_next    = low_byte_reg;
                        byte_idx_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                        if (in_bits)
                        begin
                            if (ph_reg == 2'd2)
                            begin
                                ph_next    = '0;
                                shift_next = {shift_reg[6:0], 1'b0};
                            end
                            else
                                ph_next = ph_reg + 2'd1;
                        end
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (step_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        ph_reg       <= ph_next;
        shift_reg    <= shift_next;
        byte_idx_reg <= byte_idx_next;
        if (advance)
            out_reg <= cur_step;
        if (cmd_fire)
        begin
            kind_reg     <= cmd.kind;
            low_byte_reg <= cmd.data_byte;
            nack_reg     <= cmd.nack_after_read;
            sread_reg    <= cmd.sda_read_bits;
            sack_reg     <= cmd.sda_ack_bits;
        end
    end

endmodule

/* sv/i2cps_step.sv */
// i2cps_step: decodes the sequencer position into one pin change.
// Depends on i2cps_pkg.
`timescale 1ns / 1ps

module i2cps_step
(
    input  i2cps_pkg::seq_t  st,
    output i2cps_pkg::step_t step,
    output logic             byte_done
);

    logic is_byte_out;
    logic byte_ack;
    logic [4:0] stop_idx;

    always_comb
    begin
        step        = '0;
        byte_done   = 1'b0;
        is_byte_out = 1'b0;
        byte_ack    = st.byte_idx ? st.sack[1] : st.sack[0];
        stop_idx    = st.cnt - i2cps_pkg::PULSE_END;
        case (st.kind)
            i2cps_pkg::KIND_WRITE, i2cps_pkg::KIND_ADDR7, i2cps_pkg::KIND_ADDR10:
                is_byte_out = 1'b1;
            default:
                is_byte_out = 1'b0;
        endcase

        unique case (st.kind)
            i2cps_pkg::KIND_START:
            begin
                step.pin_select = st.cnt[1] ^ st.cnt[0];
                step.pin_level  = ~st.cnt[1];
                step.last_step  = (st.cnt == i2cps_pkg::SHORT_LAST);
            end
            i2cps_pkg::KIND_STOP:
            begin
                step.pin_select = st.cnt[0];
                step.pin_level  = st.cnt[1];
                step.last_step  = (st.cnt == i2cps_pkg::SHORT_LAST);
            end
            i2cps_pkg::KIND_BRESET:
            begin
                if (st.cnt < i2cps_pkg::PULSE_END)
                begin
                    step.pin_select = i2cps_pkg::PIN_SCL;
                    step.pin_level  = st.cnt[0];
                end
                else
                begin
                    step.pin_select = stop_idx[0];
                    step.pin_level  = stop_idx[1];
                end
                step.last_step = (st.cnt == i2cps_pkg::LONG_LAST);
            end
            i2cps_pkg::KIND_READ:
            begin
                if (st.cnt == 5'd0)
                begin
                    step.pin_select = i2cps_pkg::PIN_SDA;
                    step.pin_level  = 1'b1;
                end
                else if (st.cnt <= i2cps_pkg::PULSE_END)
                begin
                    step.pin_select = i2cps_pkg::PIN_SCL;
                    step.pin_level  = st.cnt[0];
                end
                else if (st.cnt == i2cps_pkg::READ_ACK_STEP)
                begin
                    step.pin_select = i2cps_pkg::PIN_SDA;
                    step.pin_level  = st.nack;
                end
                else
                begin
                    step.pin_select = i2cps_pkg::PIN_SCL;
                    step.pin_level  = ~st.cnt[0];
                end
                step.last_step = (st.cnt == i2cps_pkg::LONG_LAST);
                if (step.last_step)
                    step.read_byte = st.sread;
            end
            i2cps_pkg::KIND_WRITE, i2cps_pkg::KIND_ADDR7, i2cps_pkg::KIND_ADDR10:
            begin
                // data bits come from the top level's bit phase; ack slot below
                step.pin_select = i2cps_pkg::PIN_SCL;
            end
            default:
            begin
                step = '0;
            end
        endcase

        // byte transfer: ack slot and end of byte
        if (is_byte_out)
        begin
            if (st.cnt >= i2cps_pkg::BYTE_BITS_END)
            begin
                unique case (st.cnt - i2cps_pkg::BYTE_BITS_END)
                    5'd0:
                    begin
                        step.pin_select = i2cps_pkg::PIN_SCL;
                        step.pin_level  = 1'b0;
                    end
                    5'd1:
                    begin
                        step.pin_select = i2cps_pkg::PIN_SDA;
                        step.pin_level  = 1'b1;
                    end
                    5'd2:
                    begin
                        step.pin_select = i2cps_pkg::PIN_SCL;
                        step.pin_level  = 1'b1;
                    end
                    default:
                    begin
                        step.pin_select = i2cps_pkg::PIN_SCL;
                        step.pin_level  = 1'b0;
                    end
                endcase
            end
            if (st.cnt == i2cps_pkg::BYTE_LAST)
            begin
                if (st.kind == i2cps_pkg::KIND_ADDR10 && !st.byte_idx && !byte_ack)
                    byte_done = 1'b1;
                else
                begin
                    step.last_step  = 1'b1;
                    step.ack_status = byte_ack;
                end
            end
        end
    end

endmodule

/* tb/i2c_master_pin_sequencer_core_tb.sv */
// i2c_master_pin_sequencer_core_tb: self-checking bench for the I2C master pin sequencer.
// It drives bus commands, predicts every SCL/SDA level change and checks each step transfer.
// Depends on i2cps_pkg and i2c_master_pin_sequencer_core.
`timescale 1ns / 1ps

module i2c_master_pin_sequencer_core_tb;

    import i2cps_pkg::*;

    // no package name for the unused command code
    localparam logic [2:0] KIND_UNDEF   = 3'd7;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         TAIL_CYCLES  = 100;
    localparam int         MAX_REPORTS  = 10;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  cmd_valid  = 1'b0;
    logic  cmd_ready;
    cmd_t  cmd        = '0;
    logic  step_valid;
    logic  step_ready = 1'b0;
    step_t step;

    cmd_t  pending_cmds[$];       // commands waiting for the driver
    step_t pin_steps_due[$];      // predicted pin changes, oldest first
    bit    cmd_taken     = 1'b0;  // command transfer at the last rising edge
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    mismatches    = 0;
    int    cycles        = 0;

    i2c_master_pin_sequencer_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Pin sequence prediction
    // ---------------------------------------------------------------
    function automatic void emit_pin(logic sel, logic lvl);
        step_t s;
        s            = '0;
        s.pin_select = sel;
        s.pin_level  = lvl;
        pin_steps_due.push_back(s);
    endfunction

    // last change of a command carries read data and ack status
    function automatic void close_command(logic [7:0] rbyte, logic ack);
        step_t s;
        s            = pin_steps_due.pop_back();
        s.read_byte  = rbyte;
        s.ack_status = ack;
        s.last_step  = 1'b1;
        pin_steps_due.push_back(s);
    endfunction

    function automatic void emit_stop();
        emit_pin(PIN_SCL, 1'b0);
        emit_pin(PIN_SDA, 1'b0);
        emit_pin(PIN_SCL, 1'b1);
        emit_pin(PIN_SDA, 1'b1);
    endfunction

    // one byte MSB first plus the ack slot; returns 1 on NACK
    function automatic logic shift_byte_out(logic [7:0] b, logic sda_at_ack);
        for (int i = BITS_PER_BYTE - 1; i >= 0; i--)
        begin
            emit_pin(PIN_SCL, 1'b0);
            emit_pin(PIN_SDA, b[i]);
            emit_pin(PIN_SCL, 1'b1);
        end
        emit_pin(PIN_SCL, 1'b0);
        emit_pin(PIN_SDA, 1'b1);
        emit_pin(PIN_SCL, 1'b1);
        emit_pin(PIN_SCL, 1'b0);
        return sda_at_ack;
    endfunction

    function automatic void expand_command(cmd_t c);
        logic       ack;
        logic [7:0] addr_byte;
        case (c.kind)
            KIND_START:
            begin
                emit_pin(PIN_SCL, 1'b1);
                emit_pin(PIN_SDA, 1'b1);
                emit_pin(PIN_SDA, 1'b0);
                emit_pin(PIN_SCL, 1'b0);
                close_command(8'h00, 1'b0);
            end
            KIND_STOP:
            begin
                emit_stop();
                close_command(8'h00, 1'b0);
            end
            KIND_BRESET:
            begin
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    emit_pin(PIN_SCL, 1'b0);
                    emit_pin(PIN_SCL, 1'b1);
                end
                emit_stop();
                close_command(8'h00, 1'b0);
            end
            KIND_WRITE:
            begin
                ack = shift_byte_out(c.data_byte, c.sda_ack_bits[0]);
                close_command(8'h00, ack);
            end
            KIND_READ:
            begin
                emit_pin(PIN_SDA, 1'b1);
                for (int i = 0; i < BITS_PER_BYTE; i++)
                begin
                    emit_pin(PIN_SCL, 1'b1);
                    emit_pin(PIN_SCL, 1'b0);
                end
                emit_pin(PIN_SDA, c.nack_after_read);
                emit_pin(PIN_SCL, 1'b1);
                emit_pin(PIN_SCL, 1'b0);
                close_command(c.sda_read_bits, 1'b0);
            end
            KIND_ADDR7:
            begin
                // address bit 7 falls off the top
                addr_byte = {c.data_byte[6:0], c.read_flag};
                ack = shift_byte_out(addr_byte, c.sda_ack_bits[0]);
                close_command(8'h00, ack);
            end
            KIND_ADDR10:
            begin
                addr_byte = ADDR10_PREFIX | {5'b0, c.addr_high_bits, c.read_flag};
                ack = shift_byte_out(addr_byte, c.sda_ack_bits[0]);
                // a NACK on the first byte ends the command early
                if (!ack)
                    ack = shift_byte_out(c.data_byte, c.sda_ack_bits[1]);
                close_command(8'h00, ack);
            end
            default:
            begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Command driver: changes at the falling edge, one NBA per signal
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_cmd
        logic next_valid;
        cmd_t next_cmd;
        next_valid = cmd_valid;
        next_cmd   = cmd;
        if (cmd_taken)
            next_valid = 1'b0;
        if (rst_n && !next_valid && pending_cmds.size() != 0
            && $urandom_range(99) >= send_idle_pct)
        begin
            next_cmd   = pending_cmds.pop_front();
            next_valid = 1'b1;
        end
        cmd_valid <= next_valid;
        cmd       <= next_cmd;
    end

    always @(negedge clk)
    begin
        step_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: predict on command transfer, then check step transfer
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch_steps
        step_t want;
        cmd_taken = rst_n && cmd_valid && cmd_ready;
        if (cmd_taken)
            expand_command(cmd);
        if (rst_n && step_valid && step_ready)
        begin
            if (pin_steps_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected step: sel=%0h lvl=%0h rd=%0h ack=%0h last=%0h",
                             step.pin_select, step.pin_level, step.read_byte,
                             step.ack_status, step.last_step);
            end
            else
            begin
                want = pin_steps_due.pop_front();
                if (step.pin_select !== want.pin_select || step.pin_level !== want.pin_level
                    || step.read_byte !== want.read_byte
                    || step.ack_status !== want.ack_status
                    || step.last_step !== want.last_step)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("step mismatch: exp sel=%0h lvl=%0h rd=%0h ack=%0h last=%0h",
                                 want.pin_select, want.pin_level, want.read_byte,
                                 want.ack_status, want.last_step);
                        $display("               got sel=%0h lvl=%0h rd=%0h ack=%0h last=%0h",
                                 step.pin_select, step.pin_level, step.read_byte,
                                 step.ack_status, step.last_step);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_cmd(logic [2:0] k, logic [7:0] data, logic [1:0] ahi, logic rd,
                             logic nack, logic [7:0] sread, logic [1:0] sack);
        cmd_t c;
        c.kind            = k;
        c.data_byte       = data;
        c.addr_high_bits  = ahi;
        c.read_flag       = rd;
        c.nack_after_read = nack;
        c.sda_read_bits   = sread;
        c.sda_ack_bits    = sack;
        pending_cmds.push_back(c);
    endtask

    // random content; addr10 mostly gets its first byte acked
    task automatic queue_random(logic [2:0] k);
        logic [1:0] sack;
        sack = 2'($urandom_range(3));
        if (k == KIND_ADDR10)
            sack[0] = ($urandom_range(3) == 0);
        queue_cmd(k, 8'($urandom_range(255)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 8'($urandom_range(255)), sack);
    endtask

    // mostly whole bus transactions, the rest loose commands
    task automatic random_traffic(int n);
        int count;
        int nbytes;
        logic [2:0] k;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(99) < 75)
            begin
                queue_random(KIND_START);
                queue_random($urandom_range(1) ? KIND_ADDR7 : KIND_ADDR10);
                nbytes = $urandom_range(1, 3);
                for (int i = 0; i < nbytes; i++)
                    queue_random($urandom_range(1) ? KIND_WRITE : KIND_READ);
                queue_random(KIND_STOP);
                count += nbytes + 3;
            end
            else
            begin
                k = 3'($urandom_range(7));
                queue_random(k);
                if (k != KIND_UNDEF)
                    count++;
            end
        end
    endtask

    // hold the stimulus back until every queued command is sent and every predicted step has been seen
    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_valid || pin_steps_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 9;
        recv_idle_pct = 77;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every command, the early and late exits
        queue_cmd(KIND_START,  8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_STOP,   8'hFF, 2'd3, 1'b1, 1'b1, 8'hFF, 2'd3);
        queue_cmd(KIND_BRESET, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_WRITE,  8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_WRITE,  8'hFF, 2'd0, 1'b0, 1'b0, 8'h00, 2'd1);
        queue_cmd(KIND_WRITE,  8'hA5, 2'd0, 1'b0, 1'b0, 8'h00, 2'd2);
        queue_cmd(KIND_READ,   8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_READ,   8'h00, 2'd0, 1'b0, 1'b1, 8'hFF, 2'd0);
        queue_cmd(KIND_READ,   8'h00, 2'd0, 1'b0, 1'b0, 8'h5A, 2'd3);
        // addr7: top bit of the byte must be dropped
        queue_cmd(KIND_ADDR7,  8'hFF, 2'd0, 1'b1, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_ADDR7,  8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd1);
        queue_cmd(KIND_ADDR7,  8'h80, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        // addr10: first-byte NACK, both acked, second-byte NACK
        queue_cmd(KIND_ADDR10, 8'h00, 2'd3, 1'b1, 1'b0, 8'h00, 2'd1);
        queue_cmd(KIND_ADDR10, 8'hFF, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        queue_cmd(KIND_ADDR10, 8'h81, 2'd2, 1'b1, 1'b0, 8'h00, 2'd2);
        queue_cmd(KIND_ADDR10, 8'h3C, 2'd1, 1'b0, 1'b0, 8'h00, 2'd3);
        // undefined code produces no steps
        queue_cmd(KIND_UNDEF,  8'hFF, 2'd3, 1'b1, 1'b1, 8'hFF, 2'd3);
        queue_cmd(KIND_START,  8'h00, 2'd0, 1'b0, 1'b0, 8'h00, 2'd0);
        drain();

        random_traffic(30);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 9;
        random_traffic(40);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(40);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pin_steps_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
